// File: design/sha_pkg.sv
// Shared types and codes for the slot handle allocator.
package sha_pkg;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CHECK  = 2'd2,
    KIND_FIND   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2,
    ST_NONE    = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
  } stat_t;

endpackage

// File: design/slot_handle_allocator.sv
// Slot handle allocator: hands out (slot index, nonzero id) handles from a
// fixed table of CAPACITY slots through a linked free list, and removes,
// checks and searches them. One operation is in flight at a time. Add,
// remove and check read the memories when the input is transferred, then
// commit once the output register can take the result. Find-next walks
// the id memory slot by slot through its single read port from the start
// index up to the first occupied slot or the high-water mark of slots ever
// handed out, then commits the same way. A high-water mark stands in for
// clearing the memories, so the block is ready right after reset. A finished
// result waits in an output register while the next item is transferred in.
module slot_handle_allocator #(
  parameter int CAPACITY = 256,
  parameter int ID_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  slot_index_i,
  input  logic [31:0] element_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  result_index_o,
  output logic [31:0] result_id_o
);

  sha_pkg::cmd_t  cmd;
  sha_pkg::stat_t stat;

  sha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sha_dp #(
    .CAPACITY(CAPACITY),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (kind_i),
    .slot_index_i  (slot_index_i),
    .element_id_i  (element_id_i),
    .status_o      (status_o),
    .result_index_o(result_index_o),
    .result_id_o   (result_id_o)
  );

endmodule

// File: design/sha_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/sha_ctrl.sv
// Controller state machine: input transfer, scan stepping and result hand-off.
module sha_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  input  sha_pkg::stat_t stat_i,
  output sha_pkg::cmd_t  cmd_o
);

  sha_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_ready;

  assign out_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sha_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = sha_pkg::S_EXEC;
        end
      end
      sha_pkg::S_EXEC: begin
        if (stat_i.done && out_ready) begin
          state_d = sha_pkg::S_IDLE;
        end
      end
      default: state_d = sha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      sha_pkg::S_IDLE: begin
        cmd_o.accept = in_valid_i;
      end
      sha_pkg::S_EXEC: begin
        // Commit only when the output register can take the result.
        cmd_o.load_out  = stat_i.done && out_ready;
        cmd_o.scan_step = !stat_i.done;
      end
      default: cmd_o = '0;
    endcase
  end

  assign out_valid_d = cmd_o.load_out ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != sha_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: design/sha_dp.sv
// Datapath: id and free-list memories, free-list head, id counter, result register.
module sha_dp #(
  parameter int CAPACITY = 256,
  parameter int ID_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha_pkg::cmd_t         cmd_i,
  output sha_pkg::stat_t        stat_o,
  input  logic [1:0]            kind_i,
  input  logic [7:0]            slot_index_i,
  input  logic [31:0]           element_id_i,
  output logic [1:0]            status_o,
  output logic [7:0]            result_index_o,
  output logic [31:0]           result_id_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int NW    = IDX_W + 1;
  localparam int CW    = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;
  localparam int EW    = (ID_BITS > 32) ? ID_BITS : 32;

  sha_pkg::kind_e   kind_q;
  logic [CW-1:0]    idx_q;
  logic [ID_BITS-1:0] id_q;
  logic [IDX_W-1:0] head_q;
  logic             empty_q;
  logic [NW-1:0]    hw_q;
  logic [ID_BITS-1:0] ctr_q;
  logic [1:0]       status_q;
  logic [7:0]       rindex_q;
  logic [31:0]      rid_q;

  logic [CW-1:0]      idx_in, idx_step, head_cw, hw_cw;
  logic [EW-1:0]      id_wide_in, id_q_w, rd_w, ctr_w;
  logic [ID_BITS-1:0] id_in, ctr_inc;
  logic [NW-1:0]      head_ext, pop_next;
  logic               in_range, hit, handle_ok;

  logic               ids_we, ids_re, nxt_we;
  logic [IDX_W-1:0]   ids_waddr, ids_raddr;
  logic [ID_BITS-1:0] ids_wdata, ids_rdata;
  logic [NW-1:0]      nxt_wdata, nxt_rdata;

  logic [1:0]  res_status;
  logic [7:0]  res_index;
  logic [31:0] res_id;

  assign idx_in     = CW'(slot_index_i);
  assign id_wide_in = EW'(element_id_i);
  assign id_in      = id_wide_in[ID_BITS-1:0];
  assign idx_step   = idx_q + CW'(1);
  assign head_cw    = CW'(head_q);
  assign head_ext   = NW'(head_q);
  assign hw_cw      = CW'(hw_q);
  assign id_q_w     = EW'(id_q);
  assign rd_w       = EW'(ids_rdata);
  assign ctr_w      = EW'(ctr_q);
  assign ctr_inc    = ctr_q + ID_BITS'(1);

  // Slots at or above the high-water mark were never handed out: they read
  // as empty and their free-list link is the next slot.
  assign in_range  = (idx_q < hw_cw);
  assign hit       = in_range && (ids_rdata != '0);
  assign handle_ok = (id_q != '0) && in_range && (ids_rdata == id_q);
  assign pop_next  = (head_ext < hw_q) ? nxt_rdata : head_ext + NW'(1);

  assign stat_o.done = (kind_q != sha_pkg::KIND_FIND) || !in_range || (ids_rdata != '0);

  assign ids_re    = cmd_i.accept || cmd_i.scan_step;
  assign ids_raddr = cmd_i.accept
                   ? ((sha_pkg::kind_e'(kind_i) == sha_pkg::KIND_ADD) ? head_q
                                                                      : idx_in[IDX_W-1:0])
                   : idx_step[IDX_W-1:0];

  always_comb begin
    ids_we     = 1'b0;
    ids_waddr  = head_q;
    ids_wdata  = ctr_q;
    nxt_we     = 1'b0;
    nxt_wdata  = empty_q ? NW'(CAPACITY) : head_ext;
    res_status = sha_pkg::ST_INVALID;
    res_index  = '0;
    res_id     = '0;
    case (kind_q)
      sha_pkg::KIND_ADD: begin
        if (empty_q) begin
          res_status = sha_pkg::ST_FULL;
        end else begin
          ids_we     = cmd_i.load_out;
          res_status = sha_pkg::ST_OK;
          res_index  = head_cw[7:0];
          res_id     = ctr_w[31:0];
        end
      end
      sha_pkg::KIND_REMOVE: begin
        ids_waddr = idx_q[IDX_W-1:0];
        ids_wdata = '0;
        if (handle_ok) begin
          ids_we     = cmd_i.load_out;
          nxt_we     = cmd_i.load_out;
          res_status = sha_pkg::ST_OK;
          res_index  = idx_q[7:0];
        end
      end
      sha_pkg::KIND_CHECK: begin
        if (handle_ok) begin
          res_status = sha_pkg::ST_OK;
          res_index  = idx_q[7:0];
          res_id     = id_q_w[31:0];
        end
      end
      sha_pkg::KIND_FIND: begin
        if (hit) begin
          res_status = sha_pkg::ST_OK;
          res_index  = idx_q[7:0];
          res_id     = rd_w[31:0];
        end else begin
          res_status = sha_pkg::ST_NONE;
        end
      end
      default: res_status = sha_pkg::ST_INVALID;
    endcase
  end

  sha_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(CAPACITY)
  ) u_ids_ram (
    .clk_i  (clk_i),
    .we_i   (ids_we),
    .waddr_i(ids_waddr),
    .wdata_i(ids_wdata),
    .re_i   (ids_re),
    .raddr_i(ids_raddr),
    .rdata_o(ids_rdata)
  );

  sha_ram #(
    .WIDTH(NW),
    .DEPTH(CAPACITY)
  ) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (nxt_we),
    .waddr_i(idx_q[IDX_W-1:0]),
    .wdata_i(nxt_wdata),
    .re_i   (cmd_i.accept),
    .raddr_i(head_q),
    .rdata_o(nxt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= sha_pkg::KIND_ADD;
      head_q  <= '0;
      empty_q <= 1'b0;
      hw_q    <= '0;
      ctr_q   <= ID_BITS'(1);
    end else begin
      if (cmd_i.accept) begin
        kind_q <= sha_pkg::kind_e'(kind_i);
      end
      if (cmd_i.load_out) begin
        if (kind_q == sha_pkg::KIND_ADD && !empty_q) begin
          // Pop the head; skip zero when the counter wraps.
          ctr_q <= (ctr_inc == '0) ? ID_BITS'(1) : ctr_inc;
          if (head_ext == hw_q) begin
            hw_q <= hw_q + NW'(1);
          end
          if (pop_next >= NW'(CAPACITY)) begin
            empty_q <= 1'b1;
            head_q  <= '0;
          end else begin
            head_q <= pop_next[IDX_W-1:0];
          end
        end else if (kind_q == sha_pkg::KIND_REMOVE && handle_ok) begin
          head_q  <= idx_q[IDX_W-1:0];
          empty_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q <= idx_in;
      id_q  <= id_in;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_step;
    end
    if (cmd_i.load_out) begin
      status_q <= res_status;
      rindex_q <= res_index;
      rid_q    <= res_id;
    end
  end

  assign status_o       = status_q;
  assign result_index_o = rindex_q;
  assign result_id_o    = rid_q;

endmodule

// File: design/sha_checker.sv
// Port-level checker for the slot handle allocator, bound to the top level.
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [7:0]  result_index_o,
  input logic [31:0] result_id_o
);

  // One item at a time: a transfer in makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // Failure results carry no handle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == sha_pkg::ST_FULL || status_o == sha_pkg::ST_INVALID
                     || status_o == sha_pkg::ST_NONE))
    |-> (result_index_o == 8'd0 && result_id_o == 32'd0))
    else $error("failure result carries a handle");

  // A result appears only after the block has been busy with an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a busy cycle");

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(result_index_o) && $stable(result_id_o)))
    else $error("stalled result changed");

endmodule

bind slot_handle_allocator sha_checker u_sha_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .result_index_o(result_index_o),
  .result_id_o   (result_id_o)
);

// File: bench/tb.sv
// Self-checking testbench for the slot handle allocator.
module tb;

  localparam int CAP          = 256;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int TOTAL_ITEMS  = 1200;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    sha_pkg::status_e status;
    logic [7:0]       index;
    logic [31:0]      id;
  } alloc_result_t;

  typedef struct packed {
    sha_pkg::kind_e kind;
    logic [7:0]     idx;
    logic [31:0]    id;
    logic           typed;
    alloc_result_t  want;
  } op_row_t;

  // Expected values are typed in only where they are obvious; the rest come from the predictor.
  localparam op_row_t DIR_ROWS [21] = '{
    '{sha_pkg::KIND_FIND,   8'd0,   32'd0,         1'b1, '{sha_pkg::ST_NONE,    8'd0, 32'd0}},
    '{sha_pkg::KIND_CHECK,  8'd0,   32'd0,         1'b1, '{sha_pkg::ST_INVALID, 8'd0, 32'd0}},
    '{sha_pkg::KIND_REMOVE, 8'd255, 32'hFFFF_FFFF, 1'b1, '{sha_pkg::ST_INVALID, 8'd0, 32'd0}},
    '{sha_pkg::KIND_ADD,    8'd0,   32'd0,         1'b1, '{sha_pkg::ST_OK,      8'd0, 32'd1}},
    '{sha_pkg::KIND_ADD,    8'd255, 32'hFFFF_FFFF, 1'b1, '{sha_pkg::ST_OK,      8'd1, 32'd2}},
    '{sha_pkg::KIND_CHECK,  8'd0,   32'd1,         1'b1, '{sha_pkg::ST_OK,      8'd0, 32'd1}},
    '{sha_pkg::KIND_CHECK,  8'd1,   32'd1,         1'b1, '{sha_pkg::ST_INVALID, 8'd0, 32'd0}},
    '{sha_pkg::KIND_CHECK,  8'd1,   32'd0,         1'b1, '{sha_pkg::ST_INVALID, 8'd0, 32'd0}},
    '{sha_pkg::KIND_FIND,   8'd0,   32'd0,         1'b0, '{sha_pkg::ST_OK,      8'd0, 32'd0}},
    '{sha_pkg::KIND_FIND,   8'd1,   32'hFFFF_FFFF, 1'b0, '{sha_pkg::ST_OK,      8'd0, 32'd0}},
    '{sha_pkg::KIND_FIND,   8'd2,   32'd0,         1'b1, '{sha_pkg::ST_NONE,    8'd0, 32'd0}},
    '{sha_pkg::KIND_FIND,   8'd255, 32'd0,         1'b1, '{sha_pkg::ST_NONE,    8'd0, 32'd0}},
    '{sha_pkg::KIND_REMOVE, 8'd0,   32'd1,         1'b1, '{sha_pkg::ST_OK,      8'd0, 32'd0}},
    '{sha_pkg::KIND_REMOVE, 8'd0,   32'd1,         1'b1, '{sha_pkg::ST_INVALID, 8'd0, 32'd0}},
    '{sha_pkg::KIND_ADD,    8'd0,   32'd0,         1'b0, '{sha_pkg::ST_OK,      8'd0, 32'd0}},
    '{sha_pkg::KIND_CHECK,  8'd0,   32'd3,         1'b0, '{sha_pkg::ST_OK,      8'd0, 32'd0}},
    '{sha_pkg::KIND_CHECK,  8'd255, 32'hFFFF_FFFF, 1'b1, '{sha_pkg::ST_INVALID, 8'd0, 32'd0}},
    '{sha_pkg::KIND_REMOVE, 8'd1,   32'd2,         1'b0, '{sha_pkg::ST_OK,      8'd0, 32'd0}},
    '{sha_pkg::KIND_FIND,   8'd0,   32'd0,         1'b0, '{sha_pkg::ST_OK,      8'd0, 32'd0}},
    '{sha_pkg::KIND_ADD,    8'd128, 32'h8000_0000, 1'b0, '{sha_pkg::ST_OK,      8'd0, 32'd0}},
    '{sha_pkg::KIND_ADD,    8'd127, 32'h7FFF_FFFF, 1'b0, '{sha_pkg::ST_OK,      8'd0, 32'd0}}
  };

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  sha_pkg::kind_e kind_i;
  logic [7:0]     slot_index_i;
  logic [31:0]    element_id_i;
  logic           out_valid_o;
  logic           out_stall_i;
  logic [1:0]     status_o;
  logic [7:0]     result_index_o;
  logic [31:0]    result_id_o;

  // Predictor state
  logic [31:0] model_ids  [CAP];
  logic        model_used [CAP];
  logic [8:0]  model_next [CAP];
  logic [7:0]  model_head;
  logic        model_empty;
  logic [31:0] model_ctr;

  alloc_result_t pending_results [$];
  int items_sent;
  int results_seen;
  int mismatches;
  int idle_cycles;

  slot_handle_allocator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .slot_index_i   (slot_index_i),
    .element_id_i   (element_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .result_index_o (result_index_o),
    .result_id_o    (result_id_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic model_clear();
    int i;
    for (i = 0; i < CAP; i++) begin
      model_ids[i]  = '0;
      model_used[i] = 1'b0;
      model_next[i] = 9'(i + 1);
    end
    model_head  = '0;
    model_empty = 1'b0;
    model_ctr   = 32'd1;
  endtask

  // Apply one operation to the predictor state and return its result.
  function automatic alloc_result_t alloc_predict(sha_pkg::kind_e k, logic [7:0] idx,
                                                  logic [31:0] id);
    alloc_result_t r;
    logic [7:0]    s;
    int            i;
    logic          valid;
    r     = '{sha_pkg::ST_OK, 8'd0, 32'd0};
    valid = (id != 0) && (model_ids[idx] == id);
    case (k)
      sha_pkg::KIND_ADD: begin
        if (model_empty) begin
          r.status = sha_pkg::ST_FULL;
        end else begin
          s             = model_head;
          model_ids[s]  = model_ctr;
          model_used[s] = 1'b1;
          r.index       = s;
          r.id          = model_ctr;
          if (model_next[s] >= 9'(CAP)) begin
            model_empty = 1'b1;
            model_head  = '0;
          end else begin
            model_head = model_next[s][7:0];
          end
          model_ctr = model_ctr + 1;
          if (model_ctr == 0) model_ctr = 32'd1;
        end
      end
      sha_pkg::KIND_REMOVE: begin
        if (!valid) begin
          r.status = sha_pkg::ST_INVALID;
        end else begin
          model_ids[idx]  = '0;
          model_used[idx] = 1'b0;
          model_next[idx] = model_empty ? 9'(CAP) : {1'b0, model_head};
          model_head      = idx;
          model_empty     = 1'b0;
          r.index         = idx;
        end
      end
      sha_pkg::KIND_CHECK: begin
        if (valid) begin
          r.index = idx;
          r.id    = id;
        end else begin
          r.status = sha_pkg::ST_INVALID;
        end
      end
      default: begin
        r.status = sha_pkg::ST_NONE;
        for (i = int'(idx); i < CAP; i++) begin
          if (model_used[i]) begin
            r = '{sha_pkg::ST_OK, 8'(i), model_ids[i]};
            break;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int pick_live();
    int start;
    int n;
    start = $urandom_range(0, CAP - 1);
    for (n = 0; n < CAP; n++) begin
      if (model_used[(start + n) % CAP]) return (start + n) % CAP;
    end
    return -1;
  endfunction

  // Offer one operation after a random gap and predict it once transferred.
  task automatic apply_op(sha_pkg::kind_e k, logic [7:0] idx, logic [31:0] id, logic typed,
                          alloc_result_t want);
    int            gap;
    alloc_result_t pred;
    gap = ((items_sent / 150) % 4 == 3) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    slot_index_i <= idx;
    element_id_i <= id;
    do @(posedge clk_i); while (in_stall_o);
    pred = alloc_predict(k, idx, id);
    pending_results.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic random_op(int add_pct, int rem_pct);
    int             r;
    int             s;
    sha_pkg::kind_e k;
    logic [7:0]     idx;
    logic [31:0]    id;
    r   = $urandom_range(0, 99);
    s   = pick_live();
    idx = 8'($urandom);
    id  = $urandom;
    if (r < add_pct || (s < 0 && r < add_pct + rem_pct + 15)) begin
      k = sha_pkg::KIND_ADD;
    end else if (r < add_pct + rem_pct) begin
      k   = sha_pkg::KIND_REMOVE;
      idx = 8'(s);
      id  = model_ids[s];
    end else if (r < add_pct + rem_pct + 15) begin
      k   = sha_pkg::KIND_CHECK;
      idx = 8'(s);
      id  = model_ids[s];
    end else if (r < add_pct + rem_pct + 30) begin
      k = sha_pkg::KIND_FIND;
      // start near a live slot half the time so the walk is short
      if (s >= 0 && r[0]) idx = 8'(s) - 8'($urandom_range(0, 3));
    end else begin
      k = sha_pkg::kind_e'($urandom_range(0, 3));
      // near-miss handle: live slot with one id bit flipped
      if (s >= 0 && r[0]) begin
        idx = 8'(s);
        id  = model_ids[s] ^ (32'd1 << $urandom_range(0, 31));
      end
    end
    apply_op(k, idx, id, 1'b0, '0);
  endtask

  initial begin : stimulus
    int s;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = sha_pkg::KIND_ADD;
    slot_index_i = '0;
    element_id_i = '0;
    out_stall_i  = 1'b0;
    items_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    model_clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[i]) begin
      apply_op(DIR_ROWS[i].kind, DIR_ROWS[i].idx, DIR_ROWS[i].id, DIR_ROWS[i].typed,
               DIR_ROWS[i].want);
    end

    repeat (350) random_op(45, 15);

    // hold off until everything in flight has come back
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);

    // fill the table, then push past full
    while (!model_empty) begin
      s = pick_live();
      if (s >= 0 && $urandom_range(0, 9) == 0)
        apply_op(sha_pkg::KIND_CHECK, 8'(s), model_ids[s], 1'b0, '0);
      else
        apply_op(sha_pkg::KIND_ADD, 8'($urandom), $urandom, 1'b0, '0);
    end
    repeat (3) apply_op(sha_pkg::KIND_ADD, 8'($urandom), $urandom, 1'b1,
                        '{sha_pkg::ST_FULL, 8'd0, 32'd0});
    // free slot 0 from a full table; it must come back and the list end again
    apply_op(sha_pkg::KIND_REMOVE, 8'd0, model_ids[0], 1'b0, '0);
    apply_op(sha_pkg::KIND_ADD, 8'd0, 32'd0, 1'b0, '0);
    apply_op(sha_pkg::KIND_ADD, 8'd0, 32'd0, 1'b1, '{sha_pkg::ST_FULL, 8'd0, 32'd0});
    apply_op(sha_pkg::KIND_FIND, 8'd255, 32'd0, 1'b0, '0);
    repeat (2) begin
      s = pick_live();
      apply_op(sha_pkg::KIND_REMOVE, 8'(s), model_ids[s], 1'b0, '0);
    end
    repeat (3) apply_op(sha_pkg::KIND_ADD, 8'($urandom), $urandom, 1'b0, '0);

    repeat (320) random_op(10, 45);
    while (items_sent < TOTAL_ITEMS) random_op(35, 25);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : result_side
    int            gap;
    bit            held;
    alloc_result_t want;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && results_seen >= 100) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else if ((results_seen / 150) % 4 == 1) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 3);
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d index %0d id %h",
                   status_o, result_index_o, result_id_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || result_index_o !== want.index ||
            result_id_o !== want.id) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected status %0d index %0d id %h, got %0d %0d %h",
                     results_seen, want.status, want.index, want.id,
                     status_o, result_index_o, result_id_o);
        end
      end
    end
  end

  // Abort when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: sim.f
design/sha_pkg.sv
design/sha_ram.sv
design/sha_ctrl.sv
design/sha_dp.sv
design/slot_handle_allocator.sv
design/sha_checker.sv
bench/tb.sv
